@@ hw/rtl/hrlt_pkg.sv @@
// Shared types and constants for the HTTP request-line tokenizer.
package hrlt_pkg;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_SL = 8'h2F;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Parse phase, one-hot
    typedef enum logic [7:0] {
        PH_METHOD  = 8'b0000_0001,
        PH_SLASH   = 8'b0000_0010,
        PH_TARGET  = 8'b0000_0100,
        PH_VERSION = 8'b0000_1000,
        PH_BAD_NL  = 8'b0001_0000,
        PH_REQ_LF  = 8'b0010_0000,
        PH_HEADER  = 8'b0100_0000,
        PH_HDR_LF  = 8'b1000_0000
    } t_phase;

    // Field tag carried with each byte
    typedef enum logic [2:0] {
        TAG_METHOD  = 3'd0,
        TAG_TARGET  = 3'd1,
        TAG_VERSION = 3'd2,
        TAG_HEADER  = 3'd3,
        TAG_DELIM   = 3'd4
    } t_tag;

    // Per-byte status
    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_SHORT = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

endpackage

@@ hw/rtl/hrlt_if.sv @@
// Valid/ready stream interfaces for the tokenizer input bytes and tagged results.
interface hrlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface hrlt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] field_tag;
    logic [1:0] status;

    modport source (output valid, output byte_out, output field_tag, output status,
                    input ready);
    modport sink   (input valid, input byte_out, input field_tag, input status,
                    output ready);
endinterface

@@ hw/rtl/http_request_line_tokenizer_core.sv @@
// HTTP request-line and header tokenizer: one tagged result per input byte.
//
// Usage:
//   i_req carries raw request bytes with a buffer_end flag on the last byte
//   currently available. o_res returns every byte unchanged, with a field tag
//   (method, target, version, header text, delimiter/discarded) and a status
//   (in progress, request complete, incomplete at buffer end, error).
//   Both channels transfer on a clock edge where valid and ready are high.
//   Each byte passes through one input register, then the parse logic
//   feeding the result register, from which it transfers on o_res.
//   Throughput is one byte per cycle while o_res is ready; the parse state
//   updates as a byte moves from the input register into the result
//   register, so each byte sees the state left by the one before it.
//   When o_res stalls, the result register holds, the input register holds
//   one more byte, and i_req.ready drops once both are full.
//   After an error the block discards bytes through the next buffer end.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   parser to expecting method bytes on an empty line, with discarding off.
module http_request_line_tokenizer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrlt_in_if.sink           i_req,
    hrlt_out_if.source        o_res
);
    import hrlt_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_tag       r_out_tag;
    t_status    r_out_status;

    // Parse state
    t_phase     r_phase;
    logic       r_line_empty;
    logic       r_error_drain;

    t_phase     n_phase;
    logic       n_line_empty;
    logic       n_error_drain;
    t_tag       n_tag;
    t_status    n_status;

    logic       out_load;
    logic       in_advance;
    logic       in_load;
    logic       bad;
    logic       done;

    // Handshake: result register loads when empty or being taken
    assign out_load   = !r_out_valid || o_res.ready;
    assign in_advance = r_in_valid && out_load;
    assign in_load    = !r_in_valid || in_advance;
    assign i_req.ready = in_load;

    // Parse one byte against the current state
    always_comb begin
        n_phase       = r_phase;
        n_line_empty  = r_line_empty;
        n_error_drain = r_error_drain;
        n_tag         = TAG_DELIM;
        n_status      = ST_BUSY;
        bad           = 1'b0;
        done          = 1'b0;

        if (r_error_drain) begin
            // discarding until buffer end
            if (r_in_last) begin
                n_error_drain = 1'b0;
                n_phase       = PH_METHOD;
                n_line_empty  = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_SLASH: begin
                    if (r_in_byte == CH_SL) n_phase = PH_TARGET;
                    else bad = 1'b1;
                end
                PH_TARGET: begin
                    if (r_in_byte == CH_SP) n_phase = PH_VERSION;
                    else if (r_in_byte == CH_CR) bad = 1'b1;
                    else n_tag = TAG_TARGET;
                end
                PH_VERSION: begin
                    if (r_in_byte == CH_SP) n_phase = PH_BAD_NL;
                    else if (r_in_byte == CH_CR) n_phase = PH_REQ_LF;
                    else n_tag = TAG_VERSION;
                end
                PH_BAD_NL: begin
                    bad = 1'b1;
                end
                PH_REQ_LF: begin
                    if (r_in_byte == CH_LF) begin
                        n_phase      = PH_HEADER;
                        n_line_empty = 1'b1;
                    end else begin
                        bad = 1'b1;
                    end
                end
                PH_HEADER: begin
                    if (r_in_byte == CH_CR) begin
                        n_phase = PH_HDR_LF;
                    end else begin
                        n_tag        = TAG_HEADER;
                        n_line_empty = 1'b0;
                    end
                end
                PH_HDR_LF: begin
                    if (r_in_byte == CH_LF) begin
                        if (r_line_empty) begin
                            done = 1'b1;
                        end else begin
                            n_phase      = PH_HEADER;
                            n_line_empty = 1'b1;
                        end
                    end else begin
                        bad = 1'b1;
                    end
                end
                default: begin
                    // method, and any stray code
                    if (r_in_byte == CH_SP) n_phase = PH_SLASH;
                    else if (r_in_byte == CH_CR) bad = 1'b1;
                    else begin
                        n_tag   = TAG_METHOD;
                        n_phase = PH_METHOD;
                    end
                end
            endcase

            // Line outcome and restart
            if (bad) begin
                n_tag         = TAG_DELIM;
                n_status      = ST_ERROR;
                n_phase       = PH_METHOD;
                n_line_empty  = 1'b1;
                n_error_drain = !r_in_last;
            end else if (done) begin
                n_status     = ST_DONE;
                n_phase      = PH_METHOD;
                n_line_empty = 1'b1;
            end else if (r_in_last) begin
                n_status     = ST_SHORT;
                n_phase      = PH_METHOD;
                n_line_empty = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_METHOD;
            r_line_empty  <= 1'b1;
            r_error_drain <= 1'b0;
        end else begin
            if (in_load) r_in_valid <= i_req.valid;
            if (out_load) r_out_valid <= r_in_valid;
            if (in_advance) begin
                r_phase       <= n_phase;
                r_line_empty  <= n_line_empty;
                r_error_drain <= n_error_drain;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_byte <= i_req.data_byte;
            r_in_last <= i_req.buffer_end;
        end
        if (in_advance) begin
            r_out_byte   <= r_in_byte;
            r_out_tag    <= n_tag;
            r_out_status <= n_status;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.byte_out  = r_out_byte;
    assign o_res.field_tag = r_out_tag;
    assign o_res.status    = r_out_status;

    // Checks
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("parse phase lost its one-hot code");

    a_drain_restarted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_drain |-> (r_phase == PH_METHOD && r_line_empty))
        else $error("discarding without a restarted parser");

    a_end_is_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_DONE || r_out_status == ST_ERROR))
        |-> (r_out_tag == TAG_DELIM))
        else $error("completing or error byte not tagged as delimiter");

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_BUSY) |-> (r_phase == PH_METHOD))
        else $error("parser not restarted after request end");

endmodule
